// ===== hdl/ppc_pkg.sv =====
// Shared types, constants and helpers for the palindromic prime check unit.
package ppc_pkg;

	// Candidate word width and derived sizes
	localparam int CandW       = 17;
	localparam int DivW        = 9;   // trial divisors stay below 512 for a 17-bit word
	localparam int SqW         = 2 * DivW;
	localparam int RevW        = 20;  // reversed digits of any 17-bit value fit here
	localparam int CntW        = 5;
	localparam int LimW        = 34;
	localparam int DecimalDigitsDefault = 5;

	localparam logic [CntW-1:0] DivLast  = CntW'(CandW - 1);
	localparam logic [DivW-1:0] FirstDiv = DivW'(2);
	localparam logic [SqW-1:0]  FirstSq  = SqW'(4);

	// ceil(2^20 / 10): (x * Recip10) >> RecipShift is x / 10 for every 17-bit x
	localparam logic [CandW-1:0] Recip10    = CandW'(104858);
	localparam int               RecipShift = 20;

	// Ten raised to a digit count, evaluated at elaboration
	function automatic logic [LimW-1:0] pow10(input int digits);
		logic [LimW-1:0] acc;
		acc = LimW'(1);
		for (int k = 0; k < digits; k++) begin
			acc = LimW'(acc * LimW'(10));
		end
		return acc;
	endfunction

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRIME_TEST,
		ST_DIV_TRIAL,
		ST_CHECK_TRIAL,
		ST_PAL_START,
		ST_DIV_PAL,
		ST_ACC_PAL,
		ST_FINISH,
		ST_RESULT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic clr_prime;
		logic div_trial;
		logic div_pal;
		logic div_step;
		logic pal_step;
		logic next_trial;
		logic acc;
		logic finish;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic below_two;
		logic bound_ok;
		logic div_last;
		logic rem_zero;
		logic quot_zero;
		logic in_range;
	} stat_t;

endpackage

// ===== hdl/ppc_datapath.sv =====
// Datapath: restoring trial divider, trial bound tracking, digit reversal, result word.
module ppc_datapath #(
	parameter int DECIMAL_DIGITS = ppc_pkg::DecimalDigitsDefault
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ppc_pkg::CandW-1:0] candidate,
	input  ppc_pkg::cmd_t             cmd,
	output ppc_pkg::stat_t            stat,
	output logic [ppc_pkg::CandW-1:0] echo_value,
	output logic                      prime_flag,
	output logic                      palindrome_flag,
	output logic                      both_flag
);

	localparam int CandW = ppc_pkg::CandW;
	localparam int DivW  = ppc_pkg::DivW;
	localparam int SqW   = ppc_pkg::SqW;
	localparam int RevW  = ppc_pkg::RevW;
	localparam int CntW  = ppc_pkg::CntW;
	localparam int LimW  = ppc_pkg::LimW;
	localparam int ProdW = 2 * CandW;
	localparam logic [LimW-1:0] Limit = ppc_pkg::pow10(DECIMAL_DIGITS);

	logic [CandW-1:0] value_q;
	logic [DivW-1:0]  b_q;
	logic [SqW-1:0]   sq_q;
	logic [CandW-1:0] quot_q;
	logic [DivW-1:0]  rem_q;
	logic [DivW-1:0]  divisor_q;
	logic [CntW-1:0]  cnt_q;
	logic [RevW-1:0]  rev_q;
	logic             prime_q;
	logic [CandW-1:0] tens_q;

	logic [DivW:0]    trial;
	logic             ge;
	logic [DivW-1:0]  rem_n;
	logic [RevW-1:0]  rev_n;
	logic             pal;
	logic [ProdW-1:0] prod10;
	logic [CandW-1:0] tens_n;
	logic [3:0]       digit;

	// One restoring division step
	always_comb begin
		trial = {rem_q, quot_q[CandW-1]};
		ge    = trial >= {1'b0, divisor_q};
		rem_n = ge ? DivW'(trial - {1'b0, divisor_q}) : trial[DivW-1:0];
	end

	// Divide the remaining digits by ten with a reciprocal multiply
	assign prod10 = ProdW'(quot_q) * ProdW'(ppc_pkg::Recip10);
	assign tens_n = CandW'(prod10 >> ppc_pkg::RecipShift);

	// Peel off the low digit and shift it into the reversed value
	assign digit = 4'(RevW'(quot_q) - RevW'({tens_q, 3'b000}) - RevW'({tens_q, 1'b0}));
	assign rev_n = RevW'({rev_q, 3'b000}) + RevW'({rev_q, 1'b0}) + RevW'(digit);
	assign pal   = stat.in_range && (rev_q == RevW'(value_q));

	// Report status
	always_comb begin
		stat.below_two = value_q < CandW'(2);
		stat.bound_ok  = sq_q <= SqW'(value_q);
		stat.div_last  = cnt_q == ppc_pkg::DivLast;
		stat.rem_zero  = rem_q == '0;
		stat.quot_zero = tens_q == '0;
		stat.in_range  = LimW'(value_q) < Limit;
	end

	// Control part of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			prime_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				prime_q <= 1'b1;
			end else if (cmd.clr_prime) begin
				prime_q <= 1'b0;
			end
			if (cmd.div_trial) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= CntW'(cnt_q + CntW'(1));
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= candidate;
			b_q     <= ppc_pkg::FirstDiv;
			sq_q    <= ppc_pkg::FirstSq;
			rev_q   <= '0;
		end
		if (cmd.next_trial) begin
			b_q  <= DivW'(b_q + DivW'(1));
			sq_q <= SqW'(sq_q + SqW'({b_q, 1'b0}) + SqW'(1));
		end
		if (cmd.div_trial) begin
			quot_q    <= value_q;
			rem_q     <= '0;
			divisor_q <= b_q;
		end else if (cmd.div_pal) begin
			quot_q <= value_q;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[CandW-2:0], ge};
			rem_q  <= rem_n;
		end else if (cmd.acc) begin
			quot_q <= tens_q;
		end
		if (cmd.pal_step) begin
			tens_q <= tens_n;
		end
		if (cmd.acc) begin
			rev_q <= rev_n;
		end
	end

	// Capture the result word
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			echo_value      <= value_q;
			prime_flag      <= prime_q;
			palindrome_flag <= pal;
			both_flag       <= prime_q && pal;
		end
	end

endmodule

// ===== hdl/ppc_ctrl.sv =====
// Controller: sequences trial divisions, digit extraction and the result strobe.
module ppc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ppc_pkg::stat_t stat,
	output ppc_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	ppc_pkg::state_t state_q;
	ppc_pkg::state_t state_n;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppc_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ppc_pkg::ST_IDLE: begin
				if (start) state_n = ppc_pkg::ST_PRIME_TEST;
			end
			ppc_pkg::ST_PRIME_TEST: begin
				if (stat.below_two || !stat.bound_ok) state_n = ppc_pkg::ST_PAL_START;
				else state_n = ppc_pkg::ST_DIV_TRIAL;
			end
			ppc_pkg::ST_DIV_TRIAL: begin
				if (stat.div_last) state_n = ppc_pkg::ST_CHECK_TRIAL;
			end
			ppc_pkg::ST_CHECK_TRIAL: begin
				if (stat.rem_zero) state_n = ppc_pkg::ST_PAL_START;
				else state_n = ppc_pkg::ST_PRIME_TEST;
			end
			ppc_pkg::ST_PAL_START: begin
				if (stat.in_range) state_n = ppc_pkg::ST_DIV_PAL;
				else state_n = ppc_pkg::ST_FINISH;
			end
			ppc_pkg::ST_DIV_PAL: state_n = ppc_pkg::ST_ACC_PAL;
			ppc_pkg::ST_ACC_PAL: begin
				if (stat.quot_zero) state_n = ppc_pkg::ST_FINISH;
				else state_n = ppc_pkg::ST_DIV_PAL;
			end
			ppc_pkg::ST_FINISH: state_n = ppc_pkg::ST_RESULT;
			ppc_pkg::ST_RESULT: state_n = ppc_pkg::ST_IDLE;
			default: state_n = ppc_pkg::ST_IDLE;
		endcase
	end

	// Drive commands
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ppc_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ppc_pkg::ST_PRIME_TEST: begin
				cmd.clr_prime = stat.below_two;
				cmd.div_trial = !stat.below_two && stat.bound_ok;
			end
			ppc_pkg::ST_DIV_TRIAL: cmd.div_step = 1'b1;
			ppc_pkg::ST_CHECK_TRIAL: begin
				cmd.clr_prime  = stat.rem_zero;
				cmd.next_trial = !stat.rem_zero;
			end
			ppc_pkg::ST_PAL_START: cmd.div_pal = stat.in_range;
			ppc_pkg::ST_DIV_PAL: cmd.pal_step = 1'b1;
			ppc_pkg::ST_ACC_PAL: cmd.acc = 1'b1;
			ppc_pkg::ST_FINISH: cmd.finish = 1'b1;
			ppc_pkg::ST_RESULT: done = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

// ===== hdl/palindromic_prime_check_unit.sv =====
// Top level: palindromic prime check with a bit-serial trial divider and a divide-by-ten unit.
// Work: one 17-step trial division per trial divisor tried (b*b <= candidate), then one
// divide-by-ten and accumulate pass per decimal digit, then the FINISH and RESULT states.
// Throughput: one word at a time; start is taken only while busy is low, the cycle after done.
// The result word holds until the next result; done is high for one cycle, without stall.
// Reset (arst_n low) returns the controller to idle and drops busy and done at once.
module palindromic_prime_check_unit #(
	parameter int DECIMAL_DIGITS = ppc_pkg::DecimalDigitsDefault
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ppc_pkg::CandW-1:0] candidate,
	output logic                      busy,
	output logic                      done,
	output logic [ppc_pkg::CandW-1:0] echo_value,
	output logic                      prime_flag,
	output logic                      palindrome_flag,
	output logic                      both_flag
);

	ppc_pkg::cmd_t  cmd;
	ppc_pkg::stat_t stat;

	// Sequence the work
	ppc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Divide, reverse and hold the result word
	ppc_datapath #(
		.DECIMAL_DIGITS (DECIMAL_DIGITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.candidate       (candidate),
		.cmd             (cmd),
		.stat            (stat),
		.echo_value      (echo_value),
		.prime_flag      (prime_flag),
		.palindrome_flag (palindrome_flag),
		.both_flag       (both_flag)
	);

endmodule
